FILE: rtl/core/encoder_speed_pid_top_defines.svh
// encoder_speed_pid_top_defines.svh: assertion macros for the encoder speed pid block
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ENCODER_SPEED_PID_TOP_DEFINES_SVH
`define ENCODER_SPEED_PID_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// concurrent check sampled on the rising clock edge, off during reset
`define ESP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be seen on a clock edge
`define ESP_NEVER(label, clk, rst, cond, msg) \
   `ESP_ASSERT(label, clk, rst, !(cond), msg)
`else
`define ESP_ASSERT(label, clk, rst, prop, msg)
`define ESP_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/core/esp_pkg.sv
// esp_pkg: types, constants and helpers for the encoder speed pid block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package esp_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int GAIN_W         = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_SCALE  = 3'd4;

   // input action codes
   localparam logic ACT_EDGE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // product terms run through the shared multiplier
   localparam logic [1:0] TERM_SPD = 2'd0;
   localparam logic [1:0] TERM_P   = 2'd1;
   localparam logic [1:0] TERM_D   = 2'd2;
   localparam logic [1:0] TERM_I   = 2'd3;

   localparam int ERR_W   = 32;             // 150 * 2^23 fits in 31 bits
   localparam int MAG_W   = 40;             // magnitude after the q8.8 shift
   localparam int SCL_W   = MAG_W + 1;      // signed scaled term
   localparam int INTEG_W = 48;
   localparam int LIM_W   = 32;
   localparam int TOTAL_W = INTEG_W + 2;
   localparam int FRAC_W  = 16;
   localparam int SHIFT_Q = 8;              // q8.8 gain product
   localparam int SHIFT_I = 9;              // integral also halves

   localparam int DIV_STEP_BITS = 8;
   localparam int DIV_STEPS     = MAG_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   localparam int ERR_SCALE_C = 150 * 256;
   localparam int LIM_MUL_C   = 130 * 256;
   localparam int LIM_OFS_C   = 40 * 65536;
   localparam int DRIVE_HI_C  = 255;
   localparam int DRIVE_LO_C  = -32768;
   localparam int SPD_MAX_C   = 32767;
   localparam int SPD_MIN_C   = -32768;

   typedef struct packed {
      logic action;
      logic chan_a;
      logic chan_b;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [15:0] measured_speed;
   } rsp_type;

   typedef struct packed {
      logic       edge_en;
      logic       count_clr;
      logic [1:0] term;
      logic       mul_en;
      logic       scl_load;
      logic       div_step;
      logic       cap_en;
      logic       err_en;
      logic       integ1_en;
      logic       integ2_en;
      logic       sum_en;
      logic       out_load;
   } esp_cmd_type;

   typedef struct packed {
      logic out_free;
   } esp_sts_type;

   function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [INTEG_W:0] v);
      logic signed [INTEG_W-1:0] r;
      if (v[INTEG_W] != v[INTEG_W-1]) begin
         r = v[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         r = v[INTEG_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/encoder_speed_pid_top.sv
// encoder_speed_pid_top: top level of the quadrature edge counter and pid speed loop
// depends on esp_pkg, esp_ctrl, esp_datapath and encoder_speed_pid_top_defines.svh
`timescale 1ns / 1ps
`include "encoder_speed_pid_top_defines.svh"

// Quadrature edge counter with a PID speed loop. An edge beat (action 0)
// moves the signed counter up when chan_a equals chan_b and down otherwise;
// it gives no response. A tick beat (action 1) turns the count into a speed
// (count times the q8.8 count_scale), clears the count and runs one PID step
// on |target_speed| and |speed|, returning one response beat with the
// saturated drive and the measured speed. A tick occupies the block until its
// response is loaded, which waits while a previous response is held by a
// stalled rsp_ready; req_ready returns in the cycle after the load. One shared
// 33x17 multiplier serves the speed, P, D and I products in turn, and a
// divide-by-ten unit yields 8 quotient bits a cycle for the D and I terms.
// Edge beats are taken back to back whenever no tick is in flight. The user
// must write registers through csr_we, csr_index and csr_wdata only while the
// block is idle; the block itself does not enforce this.
module encoder_speed_pid_top import esp_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   esp_cmd_type cmd;
   esp_sts_type sts;

   // sequencer: owns the handshake on the request side
   esp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // arithmetic, state and the response register
   esp_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   // a response beat only appears after the sequencer loads it
   `ESP_ASSERT(a_rsp_after_load, clock, reset, $rose(rsp_valid) |-> $past(cmd.out_load), "response without load")
   // loading over a stalled response would drop a beat
   `ESP_ASSERT(a_load_when_free, clock, reset, cmd.out_load |-> sts.out_free, "response overwritten")
   // the counter steps up or down only on an accepted edge beat
   `ESP_ASSERT(a_edge_accepted, clock, reset, cmd.edge_en |-> (req_valid && req_ready && req_data.action == ACT_EDGE), "count moved without edge beat")
   // the count clear of a tick never meets an edge update
   `ESP_NEVER(a_clr_vs_edge, clock, reset, cmd.edge_en && cmd.count_clr, "edge and clear together")

endmodule

FILE: rtl/core/esp_div10.sv
// esp_div10: iterative unsigned divide by ten, several quotient bits per cycle
// depends on esp_pkg
`timescale 1ns / 1ps

module esp_div10 import esp_pkg::*; #(
   parameter int WIDTH     = MAG_W,
   parameter int STEP_BITS = DIV_STEP_BITS
) (
   input  logic             clock,
   input  logic             load,
   input  logic [WIDTH-1:0] load_val,
   input  logic             step,
   output logic [WIDTH-1:0] quot
);

   localparam logic [4:0] TEN = 5'd10;

   logic [WIDTH-1:0] num_ff, num_in;
   logic [3:0]       rem_ff, rem_in;
   logic [4:0]       r5;
   logic             ge;

   // dividend shifts out at the top, quotient bits shift in at the bottom
   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      r5     = '0;
      ge     = 1'b0;
      for (int i = 0; i < STEP_BITS; i++) begin
         r5     = {rem_in, num_in[WIDTH-1]};
         ge     = (r5 >= TEN);
         num_in = {num_in[WIDTH-2:0], ge};
         rem_in = ge ? 4'(r5 - TEN) : r5[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= load_val;
         rem_ff <= '0;
      end else if (step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign quot = num_ff;

endmodule

FILE: rtl/core/esp_datapath.sv
// esp_datapath: config registers, edge counter, shared multiplier, scaling and pid arithmetic
// depends on esp_pkg and esp_div10
`timescale 1ns / 1ps

module esp_datapath import esp_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  esp_cmd_type           cmd,
   output esp_sts_type           sts
);

   localparam int MUL_A_W = ((COUNT_BITS > ERR_W) ? COUNT_BITS : ERR_W) + 1;
   localparam int MUL_W   = MUL_A_W + GAIN_W + 1;

   localparam logic signed [ERR_W-1:0]   ERR_SCALE = ERR_W'(ERR_SCALE_C);
   localparam logic [LIM_W-1:0]          LIM_MUL   = LIM_W'(LIM_MUL_C);
   localparam logic [LIM_W-1:0]          LIM_OFS   = LIM_W'(LIM_OFS_C);
   localparam logic signed [SCL_W-1:0]   SPD_MAX   = SCL_W'(SPD_MAX_C);
   localparam logic signed [SCL_W-1:0]   SPD_MIN   = SCL_W'(SPD_MIN_C);
   localparam logic signed [TOTAL_W-1:0] DRV_HI_T  = TOTAL_W'(DRIVE_HI_C * 65536);
   localparam logic signed [TOTAL_W-1:0] DRV_LO_T  = TOTAL_W'(DRIVE_LO_C);
   localparam logic signed [TOTAL_W-1:0] FRAC_RND  = TOTAL_W'((1 << FRAC_W) - 1);

   // config registers
   logic [GAIN_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff, count_scale_ff;
   logic signed [15:0] target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         target_ff      <= '0;
         count_scale_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:    prop_gain_ff   <= csr_wdata;
            CSR_INTEG_GAIN:   integ_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN:   deriv_gain_ff  <= csr_wdata;
            CSR_TARGET_SPEED: target_ff      <= $signed(csr_wdata);
            CSR_COUNT_SCALE:  count_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // edge counter, wraps
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign count_in = (req_data.chan_a == req_data.chan_b) ? count_ff + 1'b1 : count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_clr) begin
         count_ff <= '0;
      end else if (cmd.edge_en) begin
         count_ff <= count_in;
      end
   end

   // shared multiplier
   logic signed [ERR_W-1:0]   err_ff, err_in, prev_ff;
   logic signed [MUL_A_W-1:0] mul_a, err_ext, prev_ext;
   logic signed [GAIN_W:0]    mul_b;
   logic signed [MUL_W-1:0]   prod_ff, prod_in;

   assign err_ext  = MUL_A_W'(err_ff);
   assign prev_ext = MUL_A_W'(prev_ff);

   always_comb begin
      mul_a = MUL_A_W'($signed(count_ff));
      mul_b = $signed({1'b0, count_scale_ff});
      case (cmd.term)
         TERM_SPD: begin
            mul_a = MUL_A_W'($signed(count_ff));
            mul_b = $signed({1'b0, count_scale_ff});
         end
         TERM_P: begin
            mul_a = err_ext;
            mul_b = $signed({1'b0, prop_gain_ff});
         end
         TERM_D: begin
            mul_a = err_ext - prev_ext;
            mul_b = $signed({1'b0, deriv_gain_ff});
         end
         default: begin
            mul_a = err_ext + prev_ext;
            mul_b = $signed({1'b0, integ_gain_ff});
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // magnitude, power-of-two shift, then optional divide by ten
   logic             prod_neg, sign_ff;
   logic [MUL_W-1:0] prod_abs;
   logic [MAG_W-1:0] scl_in, quot;
   logic signed [SCL_W-1:0] res;

   assign prod_neg = prod_ff[MUL_W-1];
   assign prod_abs = prod_neg ? MUL_W'(-prod_ff) : MUL_W'(prod_ff);
   assign scl_in   = (cmd.term == TERM_I) ? prod_abs[SHIFT_I +: MAG_W]
                                          : prod_abs[SHIFT_Q +: MAG_W];

   always_ff @(posedge clock) begin
      if (cmd.scl_load) begin
         sign_ff <= prod_neg;
      end
   end

   esp_div10 #(
      .WIDTH     (MAG_W),
      .STEP_BITS (DIV_STEP_BITS)
   ) u_div10 (
      .clock    (clock),
      .load     (cmd.scl_load),
      .load_val (scl_in),
      .step     (cmd.div_step),
      .quot     (quot)
   );

   assign res = sign_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

   // term capture
   logic signed [15:0]      spd_ff, spd_in;
   logic signed [SCL_W-1:0] p_ff, d_ff, qi_ff;

   always_comb begin
      if (res > SPD_MAX) begin
         spd_in = 16'(SPD_MAX);
      end else if (res < SPD_MIN) begin
         spd_in = 16'(SPD_MIN);
      end else begin
         spd_in = res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         case (cmd.term)
            TERM_SPD: spd_ff <= spd_in;
            TERM_P:   p_ff   <= res;
            TERM_D:   d_ff   <= res;
            default:  qi_ff  <= res;
         endcase
      end
   end

   // error and integral limit
   logic [15:0]        tmag, smag;
   logic signed [16:0] diff;
   logic [LIM_W-1:0]   lim_ff, lim_in;

   assign tmag   = target_ff[15] ? 16'(-target_ff) : 16'(target_ff);
   assign smag   = spd_ff[15] ? 16'(-spd_ff) : 16'(spd_ff);
   assign diff   = $signed({1'b0, tmag}) - $signed({1'b0, smag});
   assign err_in = ERR_W'(diff) * ERR_SCALE;
   assign lim_in = LIM_W'(tmag) * LIM_MUL + LIM_OFS;

   always_ff @(posedge clock) begin
      if (cmd.err_en) begin
         err_ff <= err_in;
         lim_ff <= lim_in;
      end
   end

   // integral with pull-back at the limit
   logic signed [INTEG_W-1:0] integ_ff, lim_s;
   logic signed [INTEG_W:0]   add1, sub2;
   logic signed [SCL_W-1:0]   qi_abs;

   assign lim_s  = INTEG_W'(lim_ff);
   assign qi_abs = qi_ff[SCL_W-1] ? -qi_ff : qi_ff;
   assign add1   = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(qi_ff);
   assign sub2   = (INTEG_W+1)'(integ_ff) - (INTEG_W+1)'(qi_abs);

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else if (cmd.integ1_en) begin
         prev_ff <= err_ff;
         if (integ_ff <= lim_s) begin
            integ_ff <= sat_integ(add1);
         end
      end else if (cmd.integ2_en) begin
         if (integ_ff >= lim_s) begin
            integ_ff <= sat_integ(sub2);
         end
      end
   end

   // output sum and drive
   logic signed [TOTAL_W-1:0] total_ff, total_in, rnd, drv_q;
   logic signed [15:0]        drive_in;

   assign total_in = TOTAL_W'(p_ff) + TOTAL_W'(d_ff) + TOTAL_W'(integ_ff);

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         total_ff <= total_in;
      end
   end

   assign rnd   = total_ff[TOTAL_W-1] ? total_ff + FRAC_RND : total_ff;
   assign drv_q = rnd >>> FRAC_W;

   always_comb begin
      if (total_ff > DRV_HI_T) begin
         drive_in = 16'(DRIVE_HI_C);
      end else if (drv_q < DRV_LO_T) begin
         drive_in = 16'(DRV_LO_T);
      end else begin
         drive_in = drv_q[15:0];
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign rsp_data_in.drive          = drive_in;
   assign rsp_data_in.measured_speed = spd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/core/esp_ctrl.sv
// esp_ctrl: sequencer that walks one sample tick through the datapath
// depends on esp_pkg
`timescale 1ns / 1ps

module esp_ctrl import esp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_action,
   output logic        req_ready,
   output esp_cmd_type cmd,
   input  esp_sts_type sts
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL  = 4'd1;
   localparam logic [3:0] ST_LOAD = 4'd2;
   localparam logic [3:0] ST_DIV  = 4'd3;
   localparam logic [3:0] ST_CAP  = 4'd4;
   localparam logic [3:0] ST_ERR  = 4'd5;
   localparam logic [3:0] ST_INT1 = 4'd6;
   localparam logic [3:0] ST_INT2 = 4'd7;
   localparam logic [3:0] ST_SUM  = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [3:0]           state_ff, state_in;
   logic [1:0]           term_ff, term_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in   = state_ff;
      term_in    = term_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.term   = term_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_TICK) begin
                  term_in  = TERM_SPD;
                  state_in = ST_MUL;
               end else begin
                  cmd.edge_en = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.count_clr = (term_ff == TERM_SPD);
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.scl_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = (term_ff == TERM_D || term_ff == TERM_I) ? ST_DIV : ST_CAP;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_CAP;
            end
         end
         ST_CAP: begin
            cmd.cap_en = 1'b1;
            case (term_ff)
               TERM_SPD: state_in = ST_ERR;
               TERM_P: begin
                  term_in  = TERM_D;
                  state_in = ST_MUL;
               end
               TERM_D: begin
                  term_in  = TERM_I;
                  state_in = ST_MUL;
               end
               default: state_in = ST_INT1;
            endcase
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            term_in    = TERM_P;
            state_in   = ST_MUL;
         end
         ST_INT1: begin
            cmd.integ1_en = 1'b1;
            state_in      = ST_INT2;
         end
         ST_INT2: begin
            cmd.integ2_en = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         term_ff    <= TERM_SPD;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         term_ff    <= term_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

FILE: dv/encoder_speed_pid_top_test.sv
// encoder_speed_pid_top_test: self-checking bench for the encoder speed pid block
// needs esp_pkg and encoder_speed_pid_top; the scoreboard class carries its own loop model
`timescale 1ns / 1ps

module encoder_speed_pid_top_test;
   import esp_pkg::*;

   // margin for a tick in flight and a stalled response to finish
   localparam int LOOP_SETTLE = 48;
   // cycles without any accepted beat before the run is called hung
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_BEATS = 160;
   localparam int PHASE_COUNT = 8;

   // scoreboard: tracks counter, error history and integrator, and queues the
   // drive and speed that each tick beat should return
   class speed_loop_board;
      localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
      localparam longint ACC_LO = -ACC_HI - 1;

      logic [15:0]               prop_gain, integ_gain, deriv_gain, count_scale;
      logic signed [15:0]        target_speed;
      logic [COUNT_BITS_DEF-1:0] edge_count;
      longint                    prev_err, integ_acc;
      rsp_type                   tick_results[$];
      int                        fails;

      function new();
         prop_gain    = '0;
         integ_gain   = '0;
         deriv_gain   = '0;
         count_scale  = '0;
         target_speed = '0;
         edge_count   = '0;
         prev_err     = 0;
         integ_acc    = 0;
         fails        = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
         case (idx)
            CSR_PROP_GAIN:    prop_gain = val;
            CSR_INTEG_GAIN:   integ_gain = val;
            CSR_DERIV_GAIN:   deriv_gain = val;
            CSR_TARGET_SPEED: target_speed = val;
            CSR_COUNT_SCALE:  count_scale = val;
            default: ;
         endcase
      endfunction

      function longint clamp48(input longint v);
         if (v > ACC_HI) return ACC_HI;
         if (v < ACC_LO) return ACC_LO;
         return v;
      endfunction

      // one pass of the speed loop; all math in 64-bit signed, divides truncate
      function rsp_type run_tick();
         longint  cnt, scale, kp, ki, kd, tq;
         longint  spd, tgt, now, err, p, d, lim, pair_sum, total, drv;
         rsp_type r;
         cnt   = signed'(edge_count);
         scale = count_scale;
         kp    = prop_gain;
         ki    = integ_gain;
         kd    = deriv_gain;
         tq    = target_speed;
         edge_count = '0;
         spd = cnt * scale / 256;
         if (spd > 32767) spd = 32767;
         if (spd < -32768) spd = -32768;
         tgt = (tq < 0 ? -tq : tq) * 256;
         now = (spd < 0 ? -spd : spd) * 256;
         err = 150 * (tgt - now);
         p   = err * kp / 256;
         d   = (err - prev_err) * kd / 2560;
         lim = 130 * tgt + 40 * 65536;
         pair_sum = prev_err + err;
         // grow while at or under the limit, then pull back if at or over it
         if (integ_acc <= lim)
            integ_acc = clamp48(integ_acc + pair_sum * ki / 5120);
         if (integ_acc >= lim)
            integ_acc = clamp48(integ_acc - (pair_sum < 0 ? -pair_sum : pair_sum) * ki / 5120);
         prev_err = err;
         total = p + d + integ_acc;
         if (total > 255 * 65536) begin
            drv = 255;
         end else begin
            drv = total / 65536;
            if (drv < -32768) drv = -32768;
         end
         r.drive          = drv[15:0];
         r.measured_speed = spd[15:0];
         return r;
      endfunction

      function void take_beat(input req_type b);
         if (b.action == ACT_EDGE) begin
            if (b.chan_a == b.chan_b) edge_count = edge_count + 1'b1;
            else edge_count = edge_count - 1'b1;
         end else begin
            tick_results.push_back(run_tick());
         end
      endfunction

      function void match_result(input rsp_type got);
         rsp_type want;
         if (tick_results.size() == 0) begin
            $error("unexpected result beat: drive %0d, measured_speed %0d",
                   got.drive, got.measured_speed);
            fails++;
            return;
         end
         want = tick_results.pop_front();
         if (got.drive !== want.drive) begin
            $error("drive mismatch: expected %0d, got %0d", want.drive, got.drive);
            fails++;
         end
         if (got.measured_speed !== want.measured_speed) begin
            $error("measured_speed mismatch: expected %0d, got %0d",
                   want.measured_speed, got.measured_speed);
            fails++;
         end
      endfunction

      function int pending();
         return tick_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   speed_loop_board board;
   // sender runs without gaps while this is set
   bit req_calm = 1'b0;

   encoder_speed_pid_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic req_type edge_beat(input bit a, input bit b);
      return '{ACT_EDGE, a, b};
   endfunction

   // channel levels ride along on a tick but must not matter
   function automatic req_type tick_beat();
      return '{ACT_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
   endfunction

   // register value: full range, small, or one of the two ends
   function automatic logic [15:0] pick_reg();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 16'h0400));
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // valid stays high from the previous beat when no gap is drawn
   task automatic send_beat(input req_type b);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      board.take_beat(b);
   endtask

   // stop sending and wait for every outstanding tick to come back
   task automatic hold_until_drained(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // leaves csr_we high so back-to-back writes follow without a gap
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.set_reg(idx, val);
   endtask

   // block must be idle, so drain and let the last tick finish first
   task automatic load_setting(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [15:0] tgt,
                               input logic [15:0] scale);
      hold_until_drained(LOOP_SETTLE);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_TARGET_SPEED, tgt);
      write_reg(CSR_COUNT_SCALE, scale);
      csr_we <= 1'b0;
   endtask

   // runs of edges mostly in one direction, then a tick; long runs push the
   // speed into saturation, stray edges in a run act as noise
   task automatic run_random_phase(input int n_beats);
      int sent, run_len, i;
      bit up, a;
      sent = 0;
      while (sent < n_beats) begin
         req_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) hold_until_drained(0);
         run_len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20)
                                                : $urandom_range(130, 260);
         up = 1'($urandom_range(0, 1));
         for (i = 0; i < run_len; i++) begin
            a = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) send_beat(edge_beat(a, 1'($urandom_range(0, 1))));
            else send_beat(edge_beat(a, up ? a : !a));
         end
         send_beat(tick_beat());
         sent += run_len + 1;
      end
   endtask

   // response side: random ready stalls, with calm stretches now and then
   initial begin : result_sink
      int gap;
      bit calm;
      calm = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 9) == 0) calm = !calm;
         gap = draw_gap(calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         board.match_result(rsp_data);
      end
   end

   // hang detector: any accepted beat on either side restarts the count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int ph;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // moderate gains: both count directions, all channel pairs, empty tick
      load_setting(16'h0100, 16'h0080, 16'h0200, 16'h0A00, 16'h1000);
      send_beat(tick_beat());
      send_beat(edge_beat(1'b0, 1'b0));
      send_beat(edge_beat(1'b1, 1'b1));
      send_beat(edge_beat(1'b0, 1'b1));
      send_beat(edge_beat(1'b1, 1'b0));
      send_beat(edge_beat(1'b1, 1'b1));
      send_beat(edge_beat(1'b0, 1'b0));
      send_beat(edge_beat(1'b1, 1'b1));
      send_beat('{ACT_TICK, 1'b1, 1'b1});
      send_beat(edge_beat(1'b0, 1'b1));
      send_beat(edge_beat(1'b1, 1'b0));
      send_beat(edge_beat(1'b0, 1'b1));
      send_beat(edge_beat(1'b1, 1'b0));
      send_beat('{ACT_TICK, 1'b0, 1'b1});
      send_beat('{ACT_TICK, 1'b1, 1'b0});

      // every register at its top end, target at its most negative
      load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF);
      send_beat(edge_beat(1'b0, 1'b0));
      send_beat(edge_beat(1'b1, 1'b1));
      send_beat(edge_beat(1'b1, 1'b1));
      send_beat(tick_beat());
      send_beat(edge_beat(1'b0, 1'b1));
      send_beat(edge_beat(1'b1, 1'b0));
      send_beat(edge_beat(1'b0, 1'b1));
      send_beat(tick_beat());
      send_beat(tick_beat());

      // random phases, the first few with some or all registers pinned to an extreme
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF);
            1: load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: load_setting(pick_reg(), pick_reg(), pick_reg(), 16'h7FFF, pick_reg());
            default: load_setting(pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                                  pick_reg());
         endcase
         run_random_phase(PHASE_BEATS);
      end

      hold_until_drained(LOOP_SETTLE);
      if (board.fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
